FILE: sv/command_frame_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// command_frame_deframer_core_macros
// Assertion helpers used by the deframer core RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DEFRAMER_CORE_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants of the command frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

	localparam int unsigned HDR_LEN_BYTES  = 4;   // big-endian length field
	localparam int unsigned SETTINGS_BYTES = 11;  // version + five 16-bit values
	localparam int unsigned SIDX_W         = 4;

	localparam logic [7:0] SETTINGS_CODE_RST = 8'd1;
	localparam logic [7:0] FRAME_CODE_RST    = 8'd2;

	// register index = paddr[2]
	localparam logic REG_SETTINGS_CODE = 1'b0;
	localparam logic REG_FRAME_CODE    = 1'b1;

	typedef enum logic [1:0] {
		PH_CMD = 2'd0,
		PH_LEN = 2'd1,
		PH_PAY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME_BYTE  = 2'd0,
		KIND_SETTINGS    = 2'd1,
		KIND_SKIPPED     = 2'd2,
		KIND_EMPTY_FRAME = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic [7:0]  version;
		logic [15:0] in_width;
		logic [15:0] in_height;
		logic [15:0] out_width;
		logic [15:0] out_height;
		logic [15:0] frame_rate;
		logic        settings_valid;
		logic [7:0]  skipped_code;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/command_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// command_frame_deframer_core
// Splits a byte stream of command/length/payload records into frame bytes,
// decoded settings results and skipped-record reports.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------
//   in       | sink      | in_valid / in_stall     | in_byte
//   out      | source    | out_valid / out_stall   | kind .. skipped_code
//   cfg      | APB slave | psel/penable/pready     | settings_code, frame_code
//
// One byte per clock while in_stall is low; each byte gives zero or one registered result.
// The parser updates its phase state in the cycle a byte is taken; the
// result register plus a one-entry skid buffer keep input flowing while the
// output side stalls. in_stall rises only when the skid entry is occupied.
// Reset clears the phase state and both valid flags and loads the code registers with their reset values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "command_frame_deframer_core_macros.svh"

module command_frame_deframer_core
	import cfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic             last_of_frame,
	output logic [7:0]       version,
	output logic [15:0]      in_width,
	output logic [15:0]      in_height,
	output logic [15:0]      out_width,
	output logic [15:0]      out_height,
	output logic [15:0]      frame_rate,
	output logic             settings_valid,
	output logic [7:0]       skipped_code
);

	// ---- configuration registers ----
	logic [7:0] settings_code_q;
	logic [7:0] frame_code_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_code_q <= SETTINGS_CODE_RST;
			frame_code_q    <= FRAME_CODE_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SETTINGS_CODE: settings_code_q <= pwdata[7:0];
				REG_FRAME_CODE:    frame_code_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SETTINGS_CODE: prdata = {24'd0, settings_code_q};
			REG_FRAME_CODE:    prdata = {24'd0, frame_code_q};
			default:           prdata = '0;
		endcase
	end

	// ---- parser ----
	logic    in_acc;
	logic    res_valid;
	result_t res;

	assign in_acc = in_valid && !in_stall;

	cfd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (in_acc),
		.in_byte       (in_byte),
		.settings_code (settings_code_q),
		.frame_code    (frame_code_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	// ---- result register + skid entry ----
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    new_res;
	logic    out_free;
	logic    load_out_from_skid, load_out_from_res, load_skid;

	assign new_res  = in_acc && res_valid;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = skid_valid_q;

	// in_acc implies the skid is empty, so only one source loads at a time
	assign load_out_from_skid = out_free && skid_valid_q;
	assign load_out_from_res  = out_free && !skid_valid_q && new_res;
	assign load_skid          = !out_free && new_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || new_res;
				skid_valid_q <= 1'b0;
			end else if (new_res) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_from_skid) begin
			out_q <= skid_q;
		end else if (load_out_from_res) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign payload_byte   = out_q.payload_byte;
	assign last_of_frame  = out_q.last_of_frame;
	assign version        = out_q.version;
	assign in_width       = out_q.in_width;
	assign in_height      = out_q.in_height;
	assign out_width      = out_q.out_width;
	assign out_height     = out_q.out_height;
	assign frame_rate     = out_q.frame_rate;
	assign settings_valid = out_q.settings_valid;
	assign skipped_code   = out_q.skipped_code;

	// ---- assertions ----
	`CFD_ASSERT_IMPL(a_skid_needs_out, skid_valid_q, out_valid_q, "skid holds item with empty output")
	`CFD_ASSERT_NEXT(a_stall_keeps_both, out_valid_q && out_stall && skid_valid_q, out_valid_q && skid_valid_q, "item lost while stalled")
	`CFD_ASSERT_IMPL(a_frame_fields_clean, out_valid_q && (kind != KIND_FRAME_BYTE), (payload_byte == 8'd0) && !last_of_frame, "frame fields set on non-frame result")
	`CFD_ASSERT_IMPL(a_valid_only_settings, out_valid_q && settings_valid, kind == KIND_SETTINGS, "settings_valid on non-settings result")

endmodule

`default_nettype wire

FILE: sv/cfd_parser.sv
// ----------------------------------------------------------------------------
// cfd_parser
// Record parser: phase state, length counter, settings shadow, result build.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_parser
	import cfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  in_byte,
	input  wire logic [7:0]  settings_code,
	input  wire logic [7:0]  frame_code,
	output logic             res_valid,
	output result_t          res
);

	phase_t              phase_q, phase_nxt;
	logic [1:0]          hidx_q, hidx_nxt;
	logic [7:0]          cmd_q, cmd_nxt;
	logic [31:0]         rem_q, rem_nxt;
	logic [SIDX_W-1:0]   sidx_q, sidx_nxt;
	logic [7:0]          shadow_q   [SETTINGS_BYTES];
	logic [7:0]          shadow_nxt [SETTINGS_BYTES];

	logic [31:0] rem_len;
	logic [31:0] rem_dec;
	logic        pay_last;
	logic        is_set;
	logic        is_frame;
	logic        end_rec;

	assign rem_len  = {rem_q[23:0], in_byte};
	assign rem_dec  = rem_q - 32'd1;
	assign pay_last = (rem_dec == 32'd0);
	assign is_set   = (cmd_q == settings_code);
	assign is_frame = (cmd_q == frame_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			hidx_q  <= '0;
			cmd_q   <= '0;
			rem_q   <= '0;
			sidx_q  <= '0;
			for (int i = 0; i < SETTINGS_BYTES; i++) begin
				shadow_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_nxt;
			hidx_q  <= hidx_nxt;
			cmd_q   <= cmd_nxt;
			rem_q   <= rem_nxt;
			sidx_q  <= sidx_nxt;
			shadow_q <= shadow_nxt;
		end
	end

	always_comb begin
		phase_nxt  = phase_q;
		hidx_nxt   = hidx_q;
		cmd_nxt    = cmd_q;
		rem_nxt    = rem_q;
		sidx_nxt   = sidx_q;
		shadow_nxt = shadow_q;
		end_rec    = 1'b0;
		res_valid  = 1'b0;
		res        = '0;

		case (phase_q)
			PH_LEN: begin
				rem_nxt  = rem_len;
				hidx_nxt = hidx_q + 2'd1;
				if (hidx_q == 2'(HDR_LEN_BYTES - 1)) begin
					hidx_nxt = '0;
					if (rem_len == 32'd0) begin
						end_rec   = 1'b1;
						phase_nxt = PH_CMD;
					end else begin
						phase_nxt = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				rem_nxt = rem_dec;
				if (is_set) begin
					if (sidx_q < SIDX_W'(SETTINGS_BYTES)) begin
						shadow_nxt[sidx_q] = in_byte;
						sidx_nxt           = sidx_q + 1'b1;
					end
					end_rec = pay_last;
				end else if (is_frame) begin
					res_valid         = 1'b1;
					res.kind          = KIND_FRAME_BYTE;
					res.payload_byte  = in_byte;
					res.last_of_frame = pay_last;
				end else begin
					end_rec = pay_last;
				end
				if (pay_last) begin
					phase_nxt = PH_CMD;
				end
			end
			default: begin
				// command byte; unused phase code behaves the same
				cmd_nxt  = in_byte;
				hidx_nxt = '0;
				rem_nxt  = '0;
				sidx_nxt = '0;
				for (int i = 0; i < SETTINGS_BYTES; i++) begin
					shadow_nxt[i] = '0;
				end
				phase_nxt = PH_LEN;
			end
		endcase

		if (end_rec) begin
			res_valid = 1'b1;
			if (is_set) begin
				res.kind       = KIND_SETTINGS;
				res.version    = shadow_nxt[0];
				res.in_width   = {shadow_nxt[1], shadow_nxt[2]};
				res.in_height  = {shadow_nxt[3], shadow_nxt[4]};
				res.out_width  = {shadow_nxt[5], shadow_nxt[6]};
				res.out_height = {shadow_nxt[7], shadow_nxt[8]};
				res.frame_rate = {shadow_nxt[9], shadow_nxt[10]};
				res.settings_valid = (res.in_width != 16'd0) && (res.in_height != 16'd0)
					&& (res.out_width != 16'd0) && (res.out_height != 16'd0);
			end else if (is_frame) begin
				res.kind = KIND_EMPTY_FRAME;
			end else begin
				res.kind         = KIND_SKIPPED;
				res.skipped_code = cmd_q;
			end
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb_command_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_command_frame_deframer_core
// Self-checking bench for the record deframer. A byte queue feeds a clocked
// driver; every accepted byte runs through a local parser that queues the
// expected results, and a clocked monitor compares each result field by field.
// Both sides idle at random. The code registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_command_frame_deframer_core
	import cfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic        last_of_frame;
	logic [7:0]  version;
	logic [15:0] in_width;
	logic [15:0] in_height;
	logic [15:0] out_width;
	logic [15:0] out_height;
	logic [15:0] frame_rate;
	logic        settings_valid;
	logic [7:0]  skipped_code;

	command_frame_deframer_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.last_of_frame  (last_of_frame),
		.version        (version),
		.in_width       (in_width),
		.in_height      (in_height),
		.out_width      (out_width),
		.out_height     (out_height),
		.frame_rate     (frame_rate),
		.settings_valid (settings_valid),
		.skipped_code   (skipped_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser mirror: code registers and record state, reset values.
	// ------------------------------------------------------------------
	logic [7:0]  set_code = SETTINGS_CODE_RST;
	logic [7:0]  frm_code = FRAME_CODE_RST;

	phase_t      parse_phase = PH_CMD;
	int unsigned len_bytes_seen = 0;
	logic [7:0]  cur_cmd = '0;
	logic [31:0] bytes_left = '0;
	int unsigned shadow_fill = 0;
	logic [7:0]  shadow [SETTINGS_BYTES] = '{default: 8'h00};

	result_t     due_results [$];    // results the block still owes, oldest first
	logic [7:0]  stream_bytes [$];   // bytes not yet offered to the block
	int unsigned fed_count = 0;
	int unsigned mismatches = 0;

	// Advance the mirror by one accepted byte; queue the result it causes.
	function automatic void deframe_byte(input logic [7:0] b);
		result_t r;
		logic    rec_done;
		r = '0;
		rec_done = 1'b0;
		case (parse_phase)
			PH_LEN: begin
				bytes_left = {bytes_left[23:0], b};
				len_bytes_seen++;
				if (len_bytes_seen >= HDR_LEN_BYTES) begin
					len_bytes_seen = 0;
					// zero length ends the record right at its header
					if (bytes_left == 0) begin
						rec_done = 1'b1;
						parse_phase = PH_CMD;
					end else begin
						parse_phase = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				bytes_left--;
				// settings wins when both codes are equal
				if (cur_cmd == set_code) begin
					if (shadow_fill < SETTINGS_BYTES) begin
						shadow[shadow_fill] = b;
						shadow_fill++;
					end
					rec_done = (bytes_left == 0);
				end else if (cur_cmd == frm_code) begin
					r.kind = KIND_FRAME_BYTE;
					r.payload_byte = b;
					r.last_of_frame = (bytes_left == 0);
					due_results = {due_results, r};
				end else begin
					rec_done = (bytes_left == 0);
				end
				if (bytes_left == 0)
					parse_phase = PH_CMD;
			end
			default: begin
				// command byte; any unused phase value lands here too
				cur_cmd = b;
				len_bytes_seen = 0;
				bytes_left = '0;
				shadow_fill = 0;
				shadow = '{default: 8'h00};
				parse_phase = PH_LEN;
			end
		endcase
		if (rec_done) begin
			if (cur_cmd == set_code) begin
				// missing payload bytes were left at zero
				r.kind = KIND_SETTINGS;
				r.version = shadow[0];
				r.in_width = {shadow[1], shadow[2]};
				r.in_height = {shadow[3], shadow[4]};
				r.out_width = {shadow[5], shadow[6]};
				r.out_height = {shadow[7], shadow[8]};
				r.frame_rate = {shadow[9], shadow[10]};
				r.settings_valid = (r.in_width != 0) && (r.in_height != 0) &&
					(r.out_width != 0) && (r.out_height != 0);
			end else if (cur_cmd == frm_code) begin
				r.kind = KIND_EMPTY_FRAME;
			end else begin
				r.kind = KIND_SKIPPED;
				r.skipped_code = cur_cmd;
			end
			due_results = {due_results, r};
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatches < 100)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Wait count for one item; every so often a calm stretch with no waits.
	function automatic int unsigned draw_wait(inout int unsigned calm_left);
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(16, 64);
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers queued bytes, holds a byte steady while stalled.
	// ------------------------------------------------------------------
	int unsigned hold_left = 0;
	int unsigned in_calm = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				deframe_byte(in_byte);
			if (!in_valid || !in_stall) begin
				if (hold_left != 0) begin
					in_valid <= 1'b0;
					hold_left <= hold_left - 1;
				end else if (stream_bytes.size() != 0) begin
					in_byte <= stream_bytes.pop_front();
					in_valid <= 1'b1;
					hold_left <= draw_wait(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result, then stalls a drawn count.
	// ------------------------------------------------------------------
	int unsigned stall_left = 0;
	int unsigned out_calm = 0;
	int unsigned stall_draw;
	result_t     want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result, kind", kind, '0);
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", kind, want.kind);
					if (payload_byte !== want.payload_byte)
						report_mismatch("payload_byte", payload_byte, want.payload_byte);
					if (last_of_frame !== want.last_of_frame)
						report_mismatch("last_of_frame", last_of_frame, want.last_of_frame);
					if (version !== want.version)
						report_mismatch("version", version, want.version);
					if (in_width !== want.in_width)
						report_mismatch("in_width", in_width, want.in_width);
					if (in_height !== want.in_height)
						report_mismatch("in_height", in_height, want.in_height);
					if (out_width !== want.out_width)
						report_mismatch("out_width", out_width, want.out_width);
					if (out_height !== want.out_height)
						report_mismatch("out_height", out_height, want.out_height);
					if (frame_rate !== want.frame_rate)
						report_mismatch("frame_rate", frame_rate, want.frame_rate);
					if (settings_valid !== want.settings_valid)
						report_mismatch("settings_valid", settings_valid, want.settings_valid);
					if (skipped_code !== want.skipped_code)
						report_mismatch("skipped_code", skipped_code, want.skipped_code);
				end
				stall_draw = draw_wait(out_calm);
				out_stall <= (stall_draw != 0);
				stall_left <= stall_draw;
			end else if (stall_left != 0) begin
				out_stall <= (stall_left > 1);
				stall_left <= stall_left - 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void push_byte(input logic [7:0] b);
		stream_bytes = {stream_bytes, b};
		fed_count++;
	endfunction

	// Header plus 'sent' payload bytes; a settings record gets a body whose
	// sizes are zero now and then so that the valid flag drops.
	task automatic add_record(input logic [7:0] code, input logic [31:0] len,
			input int unsigned sent);
		logic [7:0]  body [SETTINGS_BYTES];
		logic [15:0] v;
		push_byte(code);
		push_byte(len[31:24]);
		push_byte(len[23:16]);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
		body[0] = 8'($urandom_range(0, 255));
		for (int i = 0; i < 5; i++) begin
			v = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
			body[2 * i + 1] = v[15:8];
			body[2 * i + 2] = v[7:0];
		end
		for (int unsigned i = 0; i < sent; i++) begin
			if (code == set_code && i < SETTINGS_BYTES)
				push_byte(body[i]);
			else
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Mostly settings and frame records, some unknown commands as noise.
	task automatic add_random_records(input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		logic [7:0]  code;
		logic [31:0] len;
		stop_at = fed_count + budget;
		while (fed_count < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				code = set_code;
				pick = $urandom_range(0, 99);
				if (pick < 65)
					len = SETTINGS_BYTES;
				else if (pick < 85)
					len = $urandom_range(0, SETTINGS_BYTES - 1);
				else if (pick < 99)
					len = $urandom_range(SETTINGS_BYTES + 1, 24);
				else
					len = 32'h103;
			end else if (pick < 85) begin
				code = frm_code;
				len = ($urandom_range(0, 49) == 0) ? 32'h105 : $urandom_range(0, 12);
			end else begin
				do
					code = 8'($urandom_range(0, 255));
				while (code == set_code || code == frm_code);
				len = $urandom_range(0, 8);
			end
			add_record(code, len, len);
		end
	endtask

	// Everything offered, accepted and answered, then a short settle.
	task automatic wait_idle();
		while (stream_bytes.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle; the register takes it at the end
	// of the access cycle.
	task automatic write_code(input logic reg_idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_SETTINGS_CODE)
			set_code = value;
		else
			frm_code = value;
	endtask

	task automatic set_codes(input logic [7:0] s, input logic [7:0] f);
		wait_idle();
		write_code(REG_SETTINGS_CODE, s);
		write_code(REG_FRAME_CODE, f);
		repeat (2) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	logic [7:0] odd_code;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset codes: full settings with extreme sizes
		add_record(SETTINGS_CODE_RST, SETTINGS_BYTES, 0);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte(8'h80);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h00);
		// zero-length settings, frame and unknown record
		add_record(SETTINGS_CODE_RST, 0, 0);
		add_record(FRAME_CODE_RST, 0, 0);
		add_record(8'h77, 0, 0);
		// two-byte frame, extremes of the byte
		add_record(FRAME_CODE_RST, 2, 0);
		push_byte(8'h00);
		push_byte(8'hFF);
		// short settings: rest reads as zero
		add_record(SETTINGS_CODE_RST, 3, 0);
		push_byte(8'h07);
		push_byte(8'h00);
		push_byte(8'h05);
		// unknown command with a payload
		add_record(8'hFF, 2, 0);
		push_byte(8'h01);
		push_byte(8'h02);

		add_random_records(150);

		// extremes of the code registers, both ways round
		set_codes(8'h00, 8'hFF);
		add_random_records(150);
		set_codes(8'hFF, 8'h00);
		add_random_records(150);

		// equal codes: every such record is a settings record
		set_codes(8'h5A, 8'h5A);
		add_random_records(90);

		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		add_random_records(150);

		set_codes(SETTINGS_CODE_RST, FRAME_CODE_RST);
		// lengths using the second length byte: long settings, long frame
		add_record(set_code, 32'h103, 32'h103);
		add_record(frm_code, 32'h105, 32'h105);
		add_random_records(80);
		// unknown record whose length needs all four bytes; it never ends,
		// so nothing may come out for it
		do
			odd_code = 8'($urandom_range(0, 255));
		while (odd_code == set_code || odd_code == frm_code);
		add_record(odd_code, 32'h0101_0101, 30);

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/cfd_pkg.sv
sv/cfd_parser.sv
sv/command_frame_deframer_core.sv
verif/tb_command_frame_deframer_core.sv
